@@ src/settings_record_parser_macros.svh @@
// Assertion macros for the settings record parser.
`ifndef SETTINGS_RECORD_PARSER_MACROS_SVH
`define SETTINGS_RECORD_PARSER_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define SRP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("settings_record_parser: check failed");

// Implication into the following clock cycle.
`define SRP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("settings_record_parser: check failed");

`endif

@@ src/srp_pkg.sv @@
// Types and constants of the settings record parser.
package srp_pkg;

	// Keyer mode codes as reported on the result word.
	typedef enum logic [1:0] {
		MODE_IAMBIC_A  = 2'd0,
		MODE_IAMBIC_B  = 2'd1,
		MODE_ULTIMATIC = 2'd2,
		MODE_STRAIGHT  = 2'd3
	} key_style_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_MIN_OSC_FREQ     = 3'd0,
		REG_MAX_OSC_FREQ     = 3'd1,
		REG_DEFAULT_OSC_FREQ = 3'd2,
		REG_MIN_SPEED        = 3'd3,
		REG_MAX_SPEED        = 3'd4,
		REG_DEFAULT_SPEED    = 3'd5,
		REG_DEFAULT_MODE     = 3'd6
	} reg_index_t;

	localparam int unsigned FREQ_W  = 27;
	localparam int unsigned SPEED_W = 7;
	localparam int unsigned POS_W   = 5;
	localparam int unsigned CFG_W   = 27;

	// "T2S " read as a little-endian word: the first byte is the low byte.
	localparam logic [31:0] MAGIC_WORD = 32'h2053_3254;
	localparam logic [POS_W-1:0] MAGIC_LEN = 5'd4;

	localparam logic [FREQ_W-1:0] FREQ_SAT = 27'h7FF_FFFF;

	localparam logic [7:0] ASCII_SPACE    = 8'h20;
	localparam logic [7:0] ASCII_ZERO     = 8'h30;
	localparam logic [7:0] ASCII_NINE     = 8'h39;
	localparam logic [7:0] ASCII_A        = 8'h41;
	localparam logic [7:0] ASCII_B        = 8'h42;
	localparam logic [7:0] ASCII_U        = 8'h55;
	localparam logic [7:0] ASCII_S        = 8'h53;
	localparam logic [7:0] ASCII_CASE_BIT = 8'h20;

	localparam logic [FREQ_W-1:0]  RST_MIN_OSC_FREQ     = 27'd0;
	localparam logic [FREQ_W-1:0]  RST_MAX_OSC_FREQ     = 27'd99999999;
	localparam logic [FREQ_W-1:0]  RST_DEFAULT_OSC_FREQ = 27'd27000000;
	localparam logic [SPEED_W-1:0] RST_MIN_SPEED        = 7'd5;
	localparam logic [SPEED_W-1:0] RST_MAX_SPEED        = 7'd40;
	localparam logic [SPEED_W-1:0] RST_DEFAULT_SPEED    = 7'd18;

endpackage

@@ src/settings_record_parser.sv @@
// Settings record parser: byte-wise parse and range check of a stored settings record.
`include "settings_record_parser_macros.svh"

// The block takes a stored ASCII settings record one byte per word: "T2S ", FREQ_DIGITS
// crystal-frequency digits, a space, a keyer-mode letter (A, B, U or S, either case), a
// space and two speed digits, FREQ_DIGITS + 9 bytes in all. A word with restart high is
// taken as the first byte of a new record; after the last byte a new record starts on its
// own. Exactly one result word is given per record, on its last byte: the parsed values
// with from_record high when the magic bytes, spaces, mode letter and both ranges pass,
// otherwise the default registers with from_record low. A non-digit anywhere in a digit
// field turns that field into zero; the frequency saturates at 2^27 - 1. In straight-key
// mode the speed reads 0 and is not range checked. The block accepts one byte every clock
// cycle: each byte sits in an input register, and combinational parse logic (a compare,
// a multiply-by-ten accumulate and, on the last byte, the range compares) writes the
// parse state and, for the last byte, the result register. The result register lets the
// next byte in while a result is still waiting; the input side stalls only while the
// input register holds a byte and the result register is full and stalled. The result
// word is held in the result register, behind the input register. Registers are written
// through the cfg port and should only be changed while no record is in flight.
module settings_record_parser #(
	parameter int unsigned FREQ_DIGITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          rec_valid,
	output logic                          rec_stall,
	input  logic [7:0]                    rec_byte,
	input  logic                          restart,

	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [srp_pkg::FREQ_W-1:0]    osc_freq,
	output logic [1:0]                    key_style,
	output logic [srp_pkg::SPEED_W-1:0]   speed_wpm,
	output logic                          from_record,

	input  logic                          cfg_write,
	input  logic [2:0]                    cfg_index,
	input  logic [srp_pkg::CFG_W-1:0]     cfg_data
);

	// Byte positions within one record.
	localparam int unsigned REC_LEN = FREQ_DIGITS + 9;
	localparam logic [srp_pkg::POS_W-1:0] POS_SPACE1 = srp_pkg::POS_W'(4 + FREQ_DIGITS);
	localparam logic [srp_pkg::POS_W-1:0] POS_MODE   = srp_pkg::POS_W'(5 + FREQ_DIGITS);
	localparam logic [srp_pkg::POS_W-1:0] POS_SPACE2 = srp_pkg::POS_W'(6 + FREQ_DIGITS);
	localparam logic [srp_pkg::POS_W-1:0] POS_SPD0   = srp_pkg::POS_W'(7 + FREQ_DIGITS);
	localparam logic [srp_pkg::POS_W-1:0] POS_SPD1   = srp_pkg::POS_W'(8 + FREQ_DIGITS);
	localparam logic [srp_pkg::POS_W-1:0] POS_LAST   = srp_pkg::POS_W'(REC_LEN - 1);

	// Configuration registers.
	logic [srp_pkg::FREQ_W-1:0]  min_osc_freq_q;
	logic [srp_pkg::FREQ_W-1:0]  max_osc_freq_q;
	logic [srp_pkg::FREQ_W-1:0]  default_osc_freq_q;
	logic [srp_pkg::SPEED_W-1:0] min_speed_q;
	logic [srp_pkg::SPEED_W-1:0] max_speed_q;
	logic [srp_pkg::SPEED_W-1:0] default_speed_q;
	logic [1:0]                  default_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_osc_freq_q     <= srp_pkg::RST_MIN_OSC_FREQ;
			max_osc_freq_q     <= srp_pkg::RST_MAX_OSC_FREQ;
			default_osc_freq_q <= srp_pkg::RST_DEFAULT_OSC_FREQ;
			min_speed_q        <= srp_pkg::RST_MIN_SPEED;
			max_speed_q        <= srp_pkg::RST_MAX_SPEED;
			default_speed_q    <= srp_pkg::RST_DEFAULT_SPEED;
			default_mode_q     <= srp_pkg::MODE_IAMBIC_A;
		end else if (cfg_write) begin
			case (cfg_index)
				srp_pkg::REG_MIN_OSC_FREQ:     min_osc_freq_q     <= cfg_data;
				srp_pkg::REG_MAX_OSC_FREQ:     max_osc_freq_q     <= cfg_data;
				srp_pkg::REG_DEFAULT_OSC_FREQ: default_osc_freq_q <= cfg_data;
				srp_pkg::REG_MIN_SPEED:     min_speed_q     <= cfg_data[srp_pkg::SPEED_W-1:0];
				srp_pkg::REG_MAX_SPEED:     max_speed_q     <= cfg_data[srp_pkg::SPEED_W-1:0];
				srp_pkg::REG_DEFAULT_SPEED: default_speed_q <= cfg_data[srp_pkg::SPEED_W-1:0];
				srp_pkg::REG_DEFAULT_MODE:  default_mode_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Input register stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       restart_s1;
	logic       adv_s1;

	// The byte in the input register moves on unless the result register is held.
	assign adv_s1    = valid_s1 && !(res_valid && res_stall);
	assign rec_stall = valid_s1 && res_valid && res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rec_stall) begin
			valid_s1 <= rec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_valid && !rec_stall) begin
			byte_s1    <= rec_byte;
			restart_s1 <= restart;
		end
	end

	// Parse state.
	logic [srp_pkg::POS_W-1:0]   pos_q;
	logic                        frame_ok_q;
	logic [srp_pkg::FREQ_W-1:0]  freq_acc_q;
	logic                        freq_bad_q;
	logic [1:0]                  mode_code_q;
	logic                        mode_ok_q;
	logic [srp_pkg::SPEED_W-1:0] speed_acc_q;
	logic                        speed_bad_q;

	// State as seen by the current byte: a restart clears it first.
	logic [srp_pkg::POS_W-1:0]   cur_pos;
	logic                        cur_frame_ok;
	logic [srp_pkg::FREQ_W-1:0]  cur_freq_acc;
	logic                        cur_freq_bad;
	logic [1:0]                  cur_mode_code;
	logic                        cur_mode_ok;
	logic [srp_pkg::SPEED_W-1:0] cur_speed_acc;
	logic                        cur_speed_bad;

	// State after the current byte.
	logic                        nxt_frame_ok;
	logic [srp_pkg::FREQ_W-1:0]  nxt_freq_acc;
	logic                        nxt_freq_bad;
	logic [1:0]                  nxt_mode_code;
	logic                        nxt_mode_ok;
	logic [srp_pkg::SPEED_W-1:0] nxt_speed_acc;
	logic                        nxt_speed_bad;

	logic                        is_digit;
	logic [3:0]                  digit_val;
	logic [7:0]                  magic_byte;
	logic [7:0]                  lower_byte;
	logic [30:0]                 freq_mac;
	logic [10:0]                 speed_mac;
	logic                        is_last;

	logic [srp_pkg::FREQ_W-1:0]  fin_freq;
	logic [srp_pkg::SPEED_W-1:0] fin_speed;
	logic                        fin_straight;
	logic                        fin_ok;

	always_comb begin
		cur_pos       = restart_s1 ? '0 : pos_q;
		cur_frame_ok  = restart_s1 ? 1'b1 : frame_ok_q;
		cur_freq_acc  = restart_s1 ? '0 : freq_acc_q;
		cur_freq_bad  = restart_s1 ? 1'b0 : freq_bad_q;
		cur_mode_code = restart_s1 ? srp_pkg::MODE_IAMBIC_A : mode_code_q;
		cur_mode_ok   = restart_s1 ? 1'b0 : mode_ok_q;
		cur_speed_acc = restart_s1 ? '0 : speed_acc_q;
		cur_speed_bad = restart_s1 ? 1'b0 : speed_bad_q;

		is_digit   = (byte_s1 >= srp_pkg::ASCII_ZERO) && (byte_s1 <= srp_pkg::ASCII_NINE);
		digit_val  = 4'(byte_s1 - srp_pkg::ASCII_ZERO);
		magic_byte = 8'(srp_pkg::MAGIC_WORD >> {cur_pos[1:0], 3'b000});
		lower_byte = byte_s1 | srp_pkg::ASCII_CASE_BIT;

		// Multiply by ten as two shifts and an add.
		freq_mac  = {1'b0, cur_freq_acc, 3'b000} + {3'b000, cur_freq_acc, 1'b0}
			+ {27'd0, digit_val};
		speed_mac = {1'b0, cur_speed_acc, 3'b000} + {3'b000, cur_speed_acc, 1'b0}
			+ {7'd0, digit_val};

		nxt_frame_ok  = cur_frame_ok;
		nxt_freq_acc  = cur_freq_acc;
		nxt_freq_bad  = cur_freq_bad;
		nxt_mode_code = cur_mode_code;
		nxt_mode_ok   = cur_mode_ok;
		nxt_speed_acc = cur_speed_acc;
		nxt_speed_bad = cur_speed_bad;

		if (cur_pos < srp_pkg::MAGIC_LEN) begin
			if (byte_s1 != magic_byte) begin
				nxt_frame_ok = 1'b0;
			end
		end else if (cur_pos < POS_SPACE1) begin
			if (!is_digit) begin
				nxt_freq_bad = 1'b1;
			end else if (!cur_freq_bad) begin
				nxt_freq_acc = (freq_mac > {4'd0, srp_pkg::FREQ_SAT}) ?
					srp_pkg::FREQ_SAT : freq_mac[srp_pkg::FREQ_W-1:0];
			end
		end else if (cur_pos == POS_SPACE1 || cur_pos == POS_SPACE2) begin
			if (byte_s1 != srp_pkg::ASCII_SPACE) begin
				nxt_frame_ok = 1'b0;
			end
		end else if (cur_pos == POS_MODE) begin
			nxt_mode_ok = 1'b1;
			case (lower_byte)
				(srp_pkg::ASCII_A | srp_pkg::ASCII_CASE_BIT): nxt_mode_code = srp_pkg::MODE_IAMBIC_A;
				(srp_pkg::ASCII_B | srp_pkg::ASCII_CASE_BIT): nxt_mode_code = srp_pkg::MODE_IAMBIC_B;
				(srp_pkg::ASCII_U | srp_pkg::ASCII_CASE_BIT): nxt_mode_code = srp_pkg::MODE_ULTIMATIC;
				(srp_pkg::ASCII_S | srp_pkg::ASCII_CASE_BIT): nxt_mode_code = srp_pkg::MODE_STRAIGHT;
				default: begin
					nxt_mode_code = srp_pkg::MODE_IAMBIC_A;
					nxt_mode_ok   = 1'b0;
				end
			endcase
		end else if (cur_pos == POS_SPD0 || cur_pos == POS_SPD1) begin
			if (!is_digit) begin
				nxt_speed_bad = 1'b1;
			end else if (!cur_speed_bad) begin
				nxt_speed_acc = speed_mac[srp_pkg::SPEED_W-1:0];
			end
		end

		is_last = (cur_pos == POS_LAST);

		// Final checks, used only on the last byte of a record.
		fin_freq     = nxt_freq_bad ? '0 : nxt_freq_acc;
		fin_straight = (nxt_mode_code == srp_pkg::MODE_STRAIGHT);
		fin_speed    = (nxt_speed_bad || fin_straight) ? '0 : nxt_speed_acc;
		fin_ok       = nxt_frame_ok && nxt_mode_ok
			&& (fin_freq >= min_osc_freq_q) && (fin_freq <= max_osc_freq_q)
			&& (fin_straight
				|| ((fin_speed >= min_speed_q) && (fin_speed <= max_speed_q)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			frame_ok_q  <= 1'b1;
			freq_acc_q  <= '0;
			freq_bad_q  <= 1'b0;
			mode_code_q <= srp_pkg::MODE_IAMBIC_A;
			mode_ok_q   <= 1'b0;
			speed_acc_q <= '0;
			speed_bad_q <= 1'b0;
		end else if (adv_s1) begin
			if (is_last) begin
				// The record is complete; the next byte opens a new one.
				pos_q       <= '0;
				frame_ok_q  <= 1'b1;
				freq_acc_q  <= '0;
				freq_bad_q  <= 1'b0;
				mode_code_q <= srp_pkg::MODE_IAMBIC_A;
				mode_ok_q   <= 1'b0;
				speed_acc_q <= '0;
				speed_bad_q <= 1'b0;
			end else begin
				pos_q       <= cur_pos + 1'b1;
				frame_ok_q  <= nxt_frame_ok;
				freq_acc_q  <= nxt_freq_acc;
				freq_bad_q  <= nxt_freq_bad;
				mode_code_q <= nxt_mode_code;
				mode_ok_q   <= nxt_mode_ok;
				speed_acc_q <= nxt_speed_acc;
				speed_bad_q <= nxt_speed_bad;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv_s1 && is_last) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && is_last) begin
			osc_freq    <= fin_ok ? fin_freq : default_osc_freq_q;
			key_style   <= fin_ok ? nxt_mode_code : default_mode_q;
			speed_wpm   <= fin_ok ? fin_speed : default_speed_q;
			from_record <= fin_ok;
		end
	end

	// Terms for the checks below.
	logic shows_defaults;
	logic straight_shown;

	assign shows_defaults = (osc_freq == default_osc_freq_q) && (key_style == default_mode_q)
		&& (speed_wpm == default_speed_q);
	assign straight_shown = res_valid && from_record && (key_style == srp_pkg::MODE_STRAIGHT);

	// The position counter never passes the last byte of a record.
	`SRP_ASSERT_NOW(a_pos_in_record, 1'b1, pos_q <= POS_LAST)
	// A byte that is not the last one never produces a result.
	`SRP_ASSERT_NEXT(a_no_early_result, adv_s1 && !is_last, !res_valid)
	// A rejected record shows exactly the default registers.
	`SRP_ASSERT_NOW(a_defaults_on_reject, res_valid && !from_record, shows_defaults)
	// A straight-key record always reports speed zero.
	`SRP_ASSERT_NOW(a_straight_speed, straight_shown, speed_wpm == '0)

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the settings record parser: directed records, then random phases.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Record layout for the digit count the block is built with. With eight frequency
	// digits the largest number a record can carry (99999999) stays below 2^27 - 1, so
	// the frequency saturation in the parser cannot be reached from the record port.
	localparam int unsigned REC_DIGITS = 8;
	localparam int unsigned REC_LEN    = REC_DIGITS + 9;
	localparam int unsigned POS_SPACE1 = 4 + REC_DIGITS;
	localparam int unsigned POS_MODE   = 5 + REC_DIGITS;
	localparam int unsigned POS_SPACE2 = 6 + REC_DIGITS;
	localparam int unsigned POS_SPD0   = 7 + REC_DIGITS;
	localparam int unsigned POS_SPD1   = 8 + REC_DIGITS;

	localparam int unsigned FREQ_TOP  = 99999999;
	localparam int unsigned SPEED_TOP = 99;

	localparam time         CLK_PERIOD   = 20ns;
	// A result reaches the output through the input and result registers after the last
	// byte; wait a little longer before touching the registers or ending the run.
	localparam int unsigned DRAIN_CYCLES = 6;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	// Least number of record bytes sent per random phase.
	localparam int unsigned PHASE_WORDS  = 90;

	// One result word as the block reports it.
	typedef struct packed {
		logic [srp_pkg::FREQ_W-1:0]  freq;
		srp_pkg::key_style_t         mode;
		logic [srp_pkg::SPEED_W-1:0] speed;
		logic                        from_rec;
	} settings_word_t;

	// One row of the directed table: the record text (right-aligned, first byte leftmost),
	// how many of its bytes are sent, whether the first byte carries restart, and the
	// expected result where it is obvious at reset settings.
	typedef struct packed {
		logic [8*REC_LEN-1:0] text;
		logic [4:0]           len;
		logic                 lead_restart;
		logic                 typed;
		settings_word_t       want;
	} record_row_t;

	localparam int unsigned NUM_ROWS = 10;

	// All rows run at the reset register values: frequency 0..99999999, speed 5..40,
	// defaults 27000000 / iambic A / 18.
	localparam record_row_t DIRECTED_ROWS [0:NUM_ROWS-1] = '{
		// Plain valid record, the default values spelled out.
		'{"T2S 27000000 A 18", 5'd17, 1'b1, 1'b1,
			'{27'd27000000, srp_pkg::MODE_IAMBIC_A, 7'd18, 1'b1}},
		// Back to back without restart; lowest frequency, lowest speed, lower-case letter.
		'{"T2S 00000000 b 05", 5'd17, 1'b0, 1'b1,
			'{27'd0, srp_pkg::MODE_IAMBIC_B, 7'd5, 1'b1}},
		// All-nines frequency and the highest accepted speed.
		'{"T2S 99999999 u 40", 5'd17, 1'b0, 1'b1,
			'{27'd99999999, srp_pkg::MODE_ULTIMATIC, 7'd40, 1'b1}},
		// Straight key: the out-of-range speed digits are ignored and speed reads 0.
		'{"T2S 14060000 s 77", 5'd17, 1'b0, 1'b1,
			'{27'd14060000, srp_pkg::MODE_STRAIGHT, 7'd0, 1'b1}},
		// Magic bytes are case sensitive, so this one falls back to the defaults.
		'{"t2S 14060000 A 20", 5'd17, 1'b1, 1'b1,
			'{27'd27000000, srp_pkg::MODE_IAMBIC_A, 7'd18, 1'b0}},
		// Unknown keyer letter.
		'{"T2S 14060000 X 20", 5'd17, 1'b0, 1'b1,
			'{27'd27000000, srp_pkg::MODE_IAMBIC_A, 7'd18, 1'b0}},
		// Record cut short; the restart on the next row throws it away.
		'{"T2S 140", 5'd7, 1'b1, 1'b0, '0},
		// A non-digit zeroes the whole frequency field, which still passes min 0.
		'{"T2S 1406x000 a 12", 5'd17, 1'b1, 1'b0, '0},
		// Speed one below the minimum.
		'{"T2S 07000000 B 04", 5'd17, 1'b0, 1'b1,
			'{27'd27000000, srp_pkg::MODE_IAMBIC_A, 7'd18, 1'b0}},
		// Speed one above the maximum.
		'{"T2S 07000000 B 41", 5'd17, 1'b0, 1'b1,
			'{27'd27000000, srp_pkg::MODE_IAMBIC_A, 7'd18, 1'b0}}
	};

	// Block ports. Everything the testbench drives has a known value from time zero.
	logic                         clk         = 1'b0;
	logic                         arst_n      = 1'b0;
	logic                         rec_valid   = 1'b0;
	logic                         rec_stall;
	logic [7:0]                   rec_byte    = 8'h00;
	logic                         restart     = 1'b0;
	logic                         res_valid;
	logic                         res_stall   = 1'b0;
	logic [srp_pkg::FREQ_W-1:0]   osc_freq;
	logic [1:0]                   key_style;
	logic [srp_pkg::SPEED_W-1:0]  speed_wpm;
	logic                         from_record;
	logic                         cfg_write   = 1'b0;
	logic [2:0]                   cfg_index   = '0;
	logic [srp_pkg::CFG_W-1:0]    cfg_data    = '0;

	settings_record_parser #(
		.FREQ_DIGITS(REC_DIGITS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.rec_valid  (rec_valid),
		.rec_stall  (rec_stall),
		.rec_byte   (rec_byte),
		.restart    (restart),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.osc_freq   (osc_freq),
		.key_style  (key_style),
		.speed_wpm  (speed_wpm),
		.from_record(from_record),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Register values as the testbench believes the block holds them.
	logic [srp_pkg::FREQ_W-1:0]  lim_min_freq;
	logic [srp_pkg::FREQ_W-1:0]  lim_max_freq;
	logic [srp_pkg::FREQ_W-1:0]  dflt_freq;
	logic [srp_pkg::SPEED_W-1:0] lim_min_speed;
	logic [srp_pkg::SPEED_W-1:0] lim_max_speed;
	logic [srp_pkg::SPEED_W-1:0] dflt_speed;
	srp_pkg::key_style_t         dflt_mode;

	// Parse state of the record being assembled.
	logic [srp_pkg::POS_W-1:0]   pos_q;
	bit                          framing_good;
	logic [srp_pkg::FREQ_W-1:0]  freq_sum;
	bit                          freq_has_junk;
	srp_pkg::key_style_t         letter_mode;
	bit                          letter_good;
	logic [srp_pkg::SPEED_W-1:0] speed_sum;
	bit                          speed_has_junk;

	// Results still owed by the block, oldest first.
	settings_word_t expected_settings [$];

	// Scratch buffer for one generated record.
	logic [7:0] rec_buf [0:REC_LEN-1];

	// Idle percentages of the current phase, for the sender and the receiver.
	int unsigned idle_pct  = 0;
	int unsigned stall_pct = 0;

	int unsigned words_sent        = 0;
	int unsigned results_seen      = 0;
	int unsigned taken_from_record = 0;
	int unsigned mismatch_count    = 0;
	int unsigned settings_used     = 1;
	int unsigned cycle_count       = 0;

	task automatic clear_parser();
		pos_q          = '0;
		framing_good   = 1'b1;
		freq_sum       = '0;
		freq_has_junk  = 1'b0;
		letter_mode    = srp_pkg::MODE_IAMBIC_A;
		letter_good    = 1'b0;
		speed_sum      = '0;
		speed_has_junk = 1'b0;
	endtask

	function automatic bit is_digit(input logic [7:0] b);
		return b >= srp_pkg::ASCII_ZERO && b <= srp_pkg::ASCII_NINE;
	endfunction

	// Advances the parse by one accepted byte. On the last byte of a record it hands
	// back the result the block must give and starts over.
	task automatic parse_byte(input logic [7:0] b, input logic rst,
			output bit done, output settings_word_t res);
		logic [63:0]                 wide;
		logic [7:0]                  letter;
		logic [srp_pkg::FREQ_W-1:0]  freq;
		logic [srp_pkg::SPEED_W-1:0] spd;
		bit                          ok;
		int unsigned                 p;
		done = 1'b0;
		res  = '0;
		if (rst)
			clear_parser();
		p = pos_q;
		if (p < 4) begin
			if (b != srp_pkg::MAGIC_WORD[8*p +: 8])
				framing_good = 1'b0;
		end else if (p < POS_SPACE1) begin
			if (!is_digit(b)) begin
				freq_has_junk = 1'b1;
			end else if (!freq_has_junk) begin
				wide     = 64'(freq_sum) * 64'd10 + 64'(b - srp_pkg::ASCII_ZERO);
				freq_sum = (wide > 64'(srp_pkg::FREQ_SAT)) ? srp_pkg::FREQ_SAT
				                                           : wide[srp_pkg::FREQ_W-1:0];
			end
		end else if (p == POS_SPACE1 || p == POS_SPACE2) begin
			if (b != srp_pkg::ASCII_SPACE)
				framing_good = 1'b0;
		end else if (p == POS_MODE) begin
			// Clearing the case bit folds each lower-case letter onto its upper case.
			letter      = b & ~srp_pkg::ASCII_CASE_BIT;
			letter_good = 1'b1;
			case (letter)
				srp_pkg::ASCII_A: letter_mode = srp_pkg::MODE_IAMBIC_A;
				srp_pkg::ASCII_B: letter_mode = srp_pkg::MODE_IAMBIC_B;
				srp_pkg::ASCII_U: letter_mode = srp_pkg::MODE_ULTIMATIC;
				srp_pkg::ASCII_S: letter_mode = srp_pkg::MODE_STRAIGHT;
				default: begin
					letter_mode = srp_pkg::MODE_IAMBIC_A;
					letter_good = 1'b0;
				end
			endcase
		end else if (p == POS_SPD0 || p == POS_SPD1) begin
			if (!is_digit(b)) begin
				speed_has_junk = 1'b1;
			end else if (!speed_has_junk) begin
				wide      = 64'(speed_sum) * 64'd10 + 64'(b - srp_pkg::ASCII_ZERO);
				speed_sum = wide[srp_pkg::SPEED_W-1:0];
			end
		end

		if (p + 1 < REC_LEN) begin
			pos_q = srp_pkg::POS_W'(p + 1);
		end else begin
			freq = freq_has_junk ? '0 : freq_sum;
			spd  = speed_has_junk ? '0 : speed_sum;
			ok   = framing_good && letter_good &&
			       freq >= lim_min_freq && freq <= lim_max_freq;
			if (letter_mode == srp_pkg::MODE_STRAIGHT)
				spd = '0;
			else if (spd < lim_min_speed || spd > lim_max_speed)
				ok = 1'b0;
			if (ok)
				res = '{freq, letter_mode, spd, 1'b1};
			else
				res = '{dflt_freq, dflt_mode, dflt_speed, 1'b0};
			done = 1'b1;
			clear_parser();
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		$display("MISMATCH at result %0d: %s got %0d, expected %0d",
			results_seen, what, got, want);
	endtask

	// Sends one word. The sender may sit idle first, as idle_pct sets; once valid is up
	// it stays up with the same byte until the block takes it. Valid is left high on
	// return, so the caller either sends the next word at once or lowers it.
	task automatic send_word(input logic [7:0] b, input logic rst,
			input bit use_typed = 1'b0, input settings_word_t typed = '0);
		bit             done;
		settings_word_t res;
		while ($urandom_range(0, 99) < idle_pct) begin
			rec_valid <= 1'b0;
			@(posedge clk);
		end
		rec_valid <= 1'b1;
		rec_byte  <= b;
		restart   <= rst;
		do @(posedge clk); while (rec_stall);
		parse_byte(b, rst, done, res);
		words_sent++;
		if (done)
			expected_settings.push_back(use_typed ? typed : res);
	endtask

	// Holds the sender off until every owed result has arrived, then lets the block
	// settle.
	task automatic await_results();
		rec_valid <= 1'b0;
		while (expected_settings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input srp_pkg::reg_index_t idx,
			input logic [srp_pkg::CFG_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		case (idx)
			srp_pkg::REG_MIN_OSC_FREQ:     lim_min_freq  = value[srp_pkg::FREQ_W-1:0];
			srp_pkg::REG_MAX_OSC_FREQ:     lim_max_freq  = value[srp_pkg::FREQ_W-1:0];
			srp_pkg::REG_DEFAULT_OSC_FREQ: dflt_freq     = value[srp_pkg::FREQ_W-1:0];
			srp_pkg::REG_MIN_SPEED:        lim_min_speed = value[srp_pkg::SPEED_W-1:0];
			srp_pkg::REG_MAX_SPEED:        lim_max_speed = value[srp_pkg::SPEED_W-1:0];
			srp_pkg::REG_DEFAULT_SPEED:    dflt_speed    = value[srp_pkg::SPEED_W-1:0];
			srp_pkg::REG_DEFAULT_MODE:     dflt_mode     = srp_pkg::key_style_t'(value[1:0]);
			default: ;
		endcase
	endtask

	task automatic set_limits(input int unsigned min_f, input int unsigned max_f,
			input int unsigned def_f, input int unsigned min_s, input int unsigned max_s,
			input int unsigned def_s, input srp_pkg::key_style_t def_m);
		write_reg(srp_pkg::REG_MIN_OSC_FREQ, srp_pkg::CFG_W'(min_f));
		write_reg(srp_pkg::REG_MAX_OSC_FREQ, srp_pkg::CFG_W'(max_f));
		write_reg(srp_pkg::REG_DEFAULT_OSC_FREQ, srp_pkg::CFG_W'(def_f));
		write_reg(srp_pkg::REG_MIN_SPEED, srp_pkg::CFG_W'(min_s));
		write_reg(srp_pkg::REG_MAX_SPEED, srp_pkg::CFG_W'(max_s));
		write_reg(srp_pkg::REG_DEFAULT_SPEED, srp_pkg::CFG_W'(def_s));
		write_reg(srp_pkg::REG_DEFAULT_MODE, srp_pkg::CFG_W'(def_m));
		settings_used++;
	endtask

	// Picks a number that lands on, just outside or inside the window [lo, hi] most of
	// the time, and anywhere in 0..top otherwise.
	function automatic int unsigned pick_value(input int unsigned lo, input int unsigned hi,
			input int unsigned top);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return lo;
		if (r < 24)
			return hi;
		if (r < 30 && lo > 0)
			return lo - 1;
		if (r < 36 && hi < top)
			return hi + 1;
		if (r < 85 && lo <= hi)
			return $urandom_range(lo, hi);
		return $urandom_range(0, top);
	endfunction

	function automatic logic [7:0] non_digit();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		// Moving a digit up by 0x40 lands it on a lower-case letter.
		if (is_digit(b))
			b = b ^ 8'h40;
		return b;
	endfunction

	task automatic put_number(input int unsigned value, input int unsigned first,
			input int unsigned count);
		int unsigned k;
		for (k = count; k > 0; k--) begin
			rec_buf[first + k - 1] = srp_pkg::ASCII_ZERO + 8'(value % 10);
			value = value / 10;
		end
	endtask

	// Fills rec_buf with a well-formed record aimed at the current ranges, then now and
	// then damages a magic byte, a digit, a space or the keyer letter.
	task automatic build_record();
		int unsigned k;
		logic [7:0]  letter;
		for (k = 0; k < 4; k++)
			rec_buf[k] = srp_pkg::MAGIC_WORD[8*k +: 8];
		put_number(pick_value(lim_min_freq, lim_max_freq, FREQ_TOP), 4, REC_DIGITS);
		rec_buf[POS_SPACE1] = srp_pkg::ASCII_SPACE;
		case ($urandom_range(0, 3))
			0:       letter = srp_pkg::ASCII_A;
			1:       letter = srp_pkg::ASCII_B;
			2:       letter = srp_pkg::ASCII_U;
			default: letter = srp_pkg::ASCII_S;
		endcase
		if ($urandom_range(0, 1))
			letter = letter | srp_pkg::ASCII_CASE_BIT;
		rec_buf[POS_MODE]   = letter;
		rec_buf[POS_SPACE2] = srp_pkg::ASCII_SPACE;
		put_number(pick_value(lim_min_speed, lim_max_speed, SPEED_TOP), POS_SPD0, 2);

		if ($urandom_range(0, 99) < 6) begin
			k = $urandom_range(0, 3);
			rec_buf[k] = $urandom_range(0, 1) ? (rec_buf[k] ^ srp_pkg::ASCII_CASE_BIT)
			                                  : 8'($urandom_range(0, 255));
		end
		if ($urandom_range(0, 99) < 6)
			rec_buf[$urandom_range(4, POS_SPACE1 - 1)] = non_digit();
		if ($urandom_range(0, 99) < 6)
			rec_buf[$urandom_range(POS_SPD0, POS_SPD1)] = non_digit();
		if ($urandom_range(0, 99) < 4)
			rec_buf[POS_SPACE1] = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 99) < 4)
			rec_buf[POS_SPACE2] = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 99) < 12)
			rec_buf[POS_MODE] = 8'($urandom_range(0, 255));
	endtask

	// One random phase under fixed register values. Mostly whole records, with some
	// records cut short and some bursts of raw bytes with random restarts in between.
	// A partial record is completed before the phase ends so that nothing is in flight
	// when the registers change.
	task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct);
		int unsigned start_words;
		int unsigned recs;
		int unsigned cut;
		int unsigned k;
		int unsigned choice;
		idle_pct    = send_pct;
		stall_pct   = recv_pct;
		start_words = words_sent;
		recs        = 0;
		while (words_sent - start_words < PHASE_WORDS) begin
			choice = $urandom_range(0, 99);
			if (choice < 8) begin
				repeat ($urandom_range(1, 24))
					send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
			end else begin
				build_record();
				cut = (choice < 16) ? $urandom_range(1, REC_LEN - 1) : REC_LEN;
				// A record that does not line up with the parser position gets restart.
				for (k = 0; k < cut; k++)
					send_word(rec_buf[k], k == 0 && (pos_q != 0 || $urandom_range(0, 1)));
			end
			recs++;
			// Let the pipeline run dry now and then in the middle of a phase.
			if (recs == 3 || $urandom_range(0, 99) < 3)
				await_results();
		end
		while (pos_q != 0)
			send_word(8'($urandom_range(0, 255)), 1'b0);
		await_results();
	endtask

	// Result side: takes a word whenever valid is up and stall is down, checks it
	// against the oldest owed result, then picks the stall for the next cycle.
	task automatic check_result();
		settings_word_t want;
		results_seen++;
		if (expected_settings.size() == 0) begin
			report_mismatch("unexpected result, osc_freq", 32'(osc_freq), 32'd0);
		end else begin
			want = expected_settings.pop_front();
			if (from_record === 1'b1)
				taken_from_record++;
			if (osc_freq !== want.freq)
				report_mismatch("osc_freq", 32'(osc_freq), 32'(want.freq));
			if (key_style !== want.mode)
				report_mismatch("key_style", 32'(key_style), 32'(want.mode));
			if (speed_wpm !== want.speed)
				report_mismatch("speed_wpm", 32'(speed_wpm), 32'(want.speed));
			if (from_record !== want.from_rec)
				report_mismatch("from_record", 32'(from_record), 32'(want.from_rec));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			check_result();
		res_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("settings_record_parser test failed");
			$finish;
		end
	end

	initial begin
		record_row_t row;
		int unsigned r;
		int unsigned k;
		int unsigned ph;
		int unsigned v;
		int unsigned w;
		int unsigned s;
		int unsigned t;

		// Register values after reset.
		lim_min_freq  = srp_pkg::RST_MIN_OSC_FREQ;
		lim_max_freq  = srp_pkg::RST_MAX_OSC_FREQ;
		dflt_freq     = srp_pkg::RST_DEFAULT_OSC_FREQ;
		lim_min_speed = srp_pkg::RST_MIN_SPEED;
		lim_max_speed = srp_pkg::RST_MAX_SPEED;
		dflt_speed    = srp_pkg::RST_DEFAULT_SPEED;
		dflt_mode     = srp_pkg::MODE_IAMBIC_A;
		clear_parser();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed records at reset settings, no idling on either side. Rows with a
		// typed expectation queue that value; the rest queue what the parse predicts.
		for (r = 0; r < NUM_ROWS; r++) begin
			row = DIRECTED_ROWS[r];
			for (k = 0; k < row.len; k++)
				send_word(row.text[8*(row.len - 1 - k) +: 8],
					k == 0 && row.lead_restart, row.typed, row.want);
		end
		await_results();

		// Widest windows and the top defaults; sender idles.
		set_limits(0, FREQ_TOP, FREQ_TOP, 0, SPEED_TOP, SPEED_TOP, srp_pkg::MODE_STRAIGHT);
		run_phase(76, 0);

		// Windows of a single value and zero defaults; receiver stalls.
		v = $urandom_range(0, FREQ_TOP);
		s = $urandom_range(0, SPEED_TOP);
		set_limits(v, v, 0, s, s, 0, srp_pkg::MODE_IAMBIC_B);
		run_phase(0, 76);

		// Minimum above maximum: every record must come back as defaults.
		v = $urandom_range(1, FREQ_TOP);
		s = $urandom_range(1, SPEED_TOP);
		set_limits(v, v - 1, $urandom_range(0, FREQ_TOP), s, s - 1,
			$urandom_range(0, SPEED_TOP), srp_pkg::MODE_ULTIMATIC);
		run_phase(33, 33);

		// Random windows, some of them narrow, under each idling pattern in turn.
		for (ph = 0; ph < 4; ph++) begin
			v = $urandom_range(0, FREQ_TOP);
			w = $urandom_range(0, 1) ? v + $urandom_range(0, 2000)
			                         : $urandom_range(v, FREQ_TOP);
			if (w > FREQ_TOP)
				w = FREQ_TOP;
			s = $urandom_range(0, 60);
			t = $urandom_range(s, SPEED_TOP);
			set_limits(v, w, $urandom_range(0, FREQ_TOP), s, t,
				$urandom_range(0, SPEED_TOP), srp_pkg::key_style_t'($urandom_range(0, 3)));
			case (ph)
				0:       run_phase(0, 0);
				1:       run_phase(76, 0);
				2:       run_phase(0, 76);
				default: run_phase(33, 33);
			endcase
		end

		await_results();
		$display("Sent %0d record bytes under %0d register settings; %0d results checked.",
			words_sent, settings_used, results_seen);
		$display("%0d results came from the record; idling none, sender, receiver, both.",
			taken_from_record);
		if (mismatch_count == 0)
			$display("settings_record_parser test passed");
		else
			$display("settings_record_parser test failed");
		$finish;
	end

endmodule
